@@ hw/rtl/pfc_pkg.sv @@
// Shared types and constants for the per-flow frame counter and steering block.
package pfc_pkg;

    // Frame header and protocol constants
    localparam logic [13:0] HEADER_BYTES   = 14'd14;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;

    // Verdict codes carried in the result word
    typedef enum logic [1:0] {
        VERDICT_ABORTED  = 2'd0,
        VERDICT_PASS     = 2'd1,
        VERDICT_REDIRECT = 2'd2
    } verdict_t;

    // Top-level sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_HOLD
    } top_state_t;

    // Table scan sequencer states
    typedef enum logic {
        LK_IDLE,
        LK_SCAN
    } lookup_state_t;

    // Outcome of one table lookup
    typedef struct packed {
        logic [31:0] count;
        logic        fresh;
        logic        full;
    } pfc_lookup_res_t;

endpackage

@@ hw/rtl/per_flow_frame_counter_and_steer.sv @@
// Per-flow frame counter and steering top level: config, sequencer and output word register.
// A runt frame goes straight to the hold state; a counted frame first runs a table
// scan, where the shared key comparator walks the filled slots in order to a hit or
// a miss (one slot compared per cycle). A new frame is taken only after the last result
// word is loaded into the output register; a stalled output register holds the sequencer.
// Reset (rst_n, async low) clears the socket mask, the table fill count and all handshakes;
// table contents are not cleared, the fill count alone marks the valid slots.
module per_flow_frame_counter_and_steer #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int QUEUE_COUNT   = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,   // socket_present_mask
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata from bit 0: frame_length[13:0], source_mac[61:14], ether_type[77:62],
    // receive_queue[83:78], zero pad[87:84]
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata from bit 0: verdict[1:0], redirect_queue[7:2], flow_count[39:8],
    // new_flow[40], table_full[41], zero pad[47:42]
    output logic [47:0] m_tdata
);

    import pfc_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    top_state_t      state_reg, state_next;
    logic [63:0]     mask_reg;
    verdict_t        verdict_reg, verdict_next;
    logic [5:0]      rq_reg, rq_next;
    pfc_lookup_res_t res_reg, res_next;
    logic            out_valid_reg, out_valid_next;
    logic [47:0]     out_data_reg, out_data_next;

    logic [13:0]     in_len;
    logic [47:0]     in_mac;
    logic [15:0]     in_etype;
    logic [5:0]      in_queue;
    logic            accept;
    logic            runt;
    logic            redirect;
    logic            out_load;
    logic            lk_start;
    logic            lk_done;
    pfc_lookup_res_t lk_res;

    logic [AW-1:0]   rd_addr;
    logic [63:0]     rd_key;
    logic [31:0]     rd_count;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [63:0]     wr_key;
    logic [31:0]     wr_count;

    // Unpack the input word
    assign in_len   = s_tdata[13:0];
    assign in_mac   = s_tdata[61:14];
    assign in_etype = s_tdata[77:62];
    assign in_queue = s_tdata[83:78];

    assign accept   = s_tvalid && s_tready;
    assign runt     = in_len < HEADER_BYTES;
    assign redirect = (in_etype == ETHERTYPE_IPV4) && mask_reg[in_queue]
                      && ({26'd0, in_queue} < 32'(QUEUE_COUNT));
    assign out_load = (state_reg == ST_HOLD) && (!out_valid_reg || m_tready);
    assign lk_start = accept && !runt;

    // Hold the socket mask
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else if (cfg_wr_en)
            mask_reg <= cfg_wr_data;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = runt ? ST_HOLD : ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                if (lk_done)
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs and result capture
    always_comb
    begin
        s_tready     = 1'b0;
        verdict_next = verdict_reg;
        rq_next      = rq_reg;
        res_next     = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    res_next = '0;
                    if (runt)
                    begin
                        verdict_next = VERDICT_ABORTED;
                        rq_next      = '0;
                    end
                    else
                    begin
                        verdict_next = redirect ? VERDICT_REDIRECT : VERDICT_PASS;
                        rq_next      = redirect ? in_queue : 6'd0;
                    end
                end
            end
            ST_LOOKUP:
            begin
                if (lk_done)
                    res_next = lk_res;
            end
            ST_HOLD: ;
            default: ;
        endcase
    end

    // Output word register
    always_comb
    begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (out_load)
        begin
            out_data_next  = {6'd0, res_reg.full, res_reg.fresh, res_reg.count,
                              rq_reg, verdict_reg};
            out_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        verdict_reg  <= verdict_next;
        rq_reg       <= rq_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    pfc_lookup #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .AW            (AW),
        .CW            (CW)
    ) u_lookup (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (lk_start),
        .key      ({in_etype, in_mac}),
        .done     (lk_done),
        .res      (lk_res),
        .rd_addr  (rd_addr),
        .rd_key   (rd_key),
        .rd_count (rd_count),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_key   (wr_key),
        .wr_count (wr_count)
    );

    pfc_flow_mem #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .AW            (AW)
    ) u_flow_mem (
        .clk      (clk),
        .rd_addr  (rd_addr),
        .rd_key   (rd_key),
        .rd_count (rd_count),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_key   (wr_key),
        .wr_count (wr_count)
    );

endmodule

@@ hw/rtl/pfc_flow_mem.sv @@
// Flow table storage: key and count arrays with one write port and a registered read port.
module pfc_flow_mem #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int AW            = $clog2(TABLE_ENTRIES)
) (
    input  logic          clk,
    input  logic [AW-1:0] rd_addr,
    output logic [63:0]   rd_key,
    output logic [31:0]   rd_count,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [63:0]   wr_key,
    input  logic [31:0]   wr_count
);

    logic [63:0] key_mem [TABLE_ENTRIES];
    logic [31:0] cnt_mem [TABLE_ENTRIES];
    logic [63:0] rd_key_reg;
    logic [31:0] rd_count_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            cnt_mem[wr_addr] <= wr_count;
        end
    end

    // Read one entry; the data appears in the cycle after the address
    always_ff @(posedge clk)
    begin
        rd_key_reg   <= key_mem[rd_addr];
        rd_count_reg <= cnt_mem[rd_addr];
    end

    assign rd_key   = rd_key_reg;
    assign rd_count = rd_count_reg;

endmodule

@@ hw/rtl/pfc_lookup.sv @@
// Table scan sequencer: one shared key comparator walks the filled slots in order.
module pfc_lookup #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int AW            = $clog2(TABLE_ENTRIES),
    parameter int CW            = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [63:0]               key,
    output logic                      done,
    output pfc_pkg::pfc_lookup_res_t  res,
    output logic [AW-1:0]             rd_addr,
    input  logic [63:0]               rd_key,
    input  logic [31:0]               rd_count,
    output logic                      wr_en,
    output logic [AW-1:0]             wr_addr,
    output logic [63:0]               wr_key,
    output logic [31:0]               wr_count
);

    import pfc_pkg::*;

    localparam logic [CW-1:0] ENTRIES_C = CW'(TABLE_ENTRIES);

    lookup_state_t state_reg, state_next;
    logic [63:0]   key_reg, key_next;
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic          cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0] cmp_idx_reg, cmp_idx_next;
    logic [CW-1:0] used_reg, used_next;

    logic          match;
    logic          issue;
    logic          miss;
    logic          room;
    logic [31:0]   inc_count;

    // Compare the entry read last cycle and decide what the scan does next
    assign match     = cmp_valid_reg && (rd_key == key_reg);
    assign issue     = scan_idx_reg < used_reg;
    assign miss      = !match && !issue;
    assign room      = used_reg < ENTRIES_C;
    assign inc_count = (rd_count == COUNT_MAX) ? rd_count : rd_count + 32'd1;
    assign rd_addr   = scan_idx_reg[AW-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            LK_IDLE:
            begin
                if (start)
                    state_next = LK_SCAN;
            end
            LK_SCAN:
            begin
                if (match || miss)
                    state_next = LK_IDLE;
            end
            default: state_next = LK_IDLE;
        endcase
    end

    // Scan datapath, table writes and result
    always_comb
    begin
        key_next       = key_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        used_next      = used_reg;
        done           = 1'b0;
        res            = '0;
        wr_en          = 1'b0;
        wr_addr        = cmp_idx_reg;
        wr_key         = key_reg;
        wr_count       = inc_count;
        unique case (state_reg)
            LK_IDLE:
            begin
                if (start)
                begin
                    key_next      = key;
                    scan_idx_next = '0;
                end
            end
            LK_SCAN:
            begin
                if (match)
                begin
                    // Bump the hit entry, saturating
                    done      = 1'b1;
                    wr_en     = 1'b1;
                    res.count = inc_count;
                end
                else if (miss)
                begin
                    // Append the new key in the next free slot, or report a full table
                    done      = 1'b1;
                    res.fresh = room;
                    res.full  = !room;
                    res.count = room ? 32'd1 : 32'd0;
                    wr_en     = room;
                    wr_addr   = used_reg[AW-1:0];
                    wr_count  = 32'd1;
                    if (room)
                        used_next = used_reg + CW'(1);
                end
                else
                begin
                    // Advance to the next filled slot
                    scan_idx_next  = scan_idx_reg + CW'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg[AW-1:0];
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= LK_IDLE;
            cmp_valid_reg <= 1'b0;
            used_reg      <= '0;
            scan_idx_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            used_reg      <= used_next;
            scan_idx_reg  <= scan_idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        cmp_idx_reg <= cmp_idx_next;
    end

    // Fill count never passes the table size
    assert property (@(posedge clk) disable iff (!rst_n) used_reg <= ENTRIES_C)
        else $error("fill count beyond table size");

    // An insert grows the fill count by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.fresh) |=> (used_reg == $past(used_reg) + CW'(1)))
        else $error("insert did not advance fill count");

    // A counted frame never reports a zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !res.full) |-> (res.count != 32'd0))
        else $error("counted frame with zero count");

    // Only a scan that ends writes the table
    assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> done)
        else $error("table write outside scan end");

endmodule
